### hdl/rdj_pkg.sv
// Shared types and constants for the ranged RomuDuoJr random unit.
package rdj_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned CNT_W = $clog2(W);
  localparam int unsigned ROT_AMT = 27;

  localparam logic [W-1:0] SEED_RST  = 64'd509;
  localparam logic [W-1:0] XOR_MASK  = 64'hA5A5_A5A5_A5A5_A5A5;
  localparam logic [W-1:0] SEED_MULT = 64'h5851_F42D_4C95_7F2D;
  localparam logic [W-1:0] STEP_MULT = 64'd15241094284759029579;
  localparam logic [W-1:0] X_RST     = SEED_RST ^ XOR_MASK;
  localparam logic [W-1:0] Y_RST     = SEED_RST * SEED_MULT + 64'd1;

  typedef struct packed {
    logic         bounded;
    logic [W-1:0] range_low;
    logic [W-1:0] range_high;
  } rdj_in_t;

  typedef struct packed {
    logic [W-1:0] value;
    logic         range_error;
  } rdj_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } rdj_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_SEED_END,
    ST_DRAW,
    ST_DRAW_END,
    ST_OUT
  } rdj_state_t;

endpackage

### hdl/rdj_mul.sv
// Bit-serial shift-and-add multiplier, low word of the product.
module rdj_mul import rdj_pkg::*; (
  input  logic         clk,
  input  rdj_ctl_t     ctl,
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  output logic [W-1:0] prod
);

  logic [W-1:0] a_r, b_r, acc_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (ctl.step) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[W-2:0], 1'b0};
      b_r <= {1'b0, b_r[W-1:1]};
    end
  end

  assign prod = acc_r;

endmodule

### hdl/rdj_div.sv
// Restoring remainder unit, one dividend bit per cycle while stepped.
module rdj_div import rdj_pkg::*; (
  input  logic         clk,
  input  rdj_ctl_t     ctl,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] rem
);

  logic [W-1:0] dvd_r, dsr_r, rem_r;
  logic [W:0]   trial;

  assign trial = {rem_r, dvd_r[W-1]};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (ctl.step) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_r <= W'(trial - {1'b0, dsr_r});
      end else begin
        rem_r <= trial[W-1:0];
      end
      dvd_r <= {dvd_r[W-2:0], 1'b0};
    end
  end

  assign rem = rem_r;

endmodule

### hdl/romu_duo_jr_ranged_random_unit.sv
// Top level: RomuDuoJr generator with serial multiply and range reduction.
// A draw steps the serial multiplier and remainder unit once per word bit,
// then folds the remainder into the range and registers the result. A new
// input is accepted only in idle; inverted or single-value ranges skip the
// serial steps. A seed write reloads state through the serial multiplier,
// holding in_ready low until it completes. Reset loads seed 509 at once.
module romu_duo_jr_ranged_random_unit import rdj_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  rdj_in_t      in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output rdj_out_t     out_data,
  input  logic         cfg_wr_en,
  input  logic [W-1:0] cfg_wr_data
);

  rdj_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0] x_r, y_r, lo_r;
  logic red_r;
  rdj_out_t res_r, out_r;
  logic out_valid_r;

  rdj_ctl_t mul_ctl, div_ctl;
  logic [W-1:0] mul_a, mul_b, prod, rem;
  logic [W-1:0] span, diff;
  logic in_fire, take, go_draw;

  assign in_ready = (state_r == ST_IDLE) && !cfg_wr_en;
  assign in_fire  = in_valid && in_ready;
  assign span     = in_data.range_high - in_data.range_low + 64'd1;
  assign go_draw  = !in_data.bounded ||
                    (in_data.range_low < in_data.range_high);
  assign take     = !out_valid_r || out_ready;
  assign diff     = y_r - x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    mul_ctl      = '0;
    div_ctl      = '0;
    mul_a        = y_r;
    mul_b        = STEP_MULT;
    case (state_r)
      ST_IDLE: begin
        if (cfg_wr_en) begin
          mul_ctl.load = 1'b1;
          mul_a        = cfg_wr_data;
          mul_b        = SEED_MULT;
          state_nxt    = ST_SEED;
        end else if (in_fire) begin
          if (go_draw) begin
            mul_ctl.load = 1'b1;
            div_ctl.load = 1'b1;
            state_nxt    = ST_DRAW;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SEED: begin
        mul_ctl.step = 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          state_nxt = ST_SEED_END;
        end
      end
      ST_SEED_END: state_nxt = ST_IDLE;
      ST_DRAW: begin
        mul_ctl.step = 1'b1;
        div_ctl.step = 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          state_nxt = ST_DRAW_END;
        end
      end
      ST_DRAW_END: state_nxt = ST_OUT;
      ST_OUT: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= X_RST;
      y_r         <= Y_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (mul_ctl.load) begin
        cnt_r <= '0;
      end else if (mul_ctl.step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_IDLE && cfg_wr_en) begin
        x_r <= cfg_wr_data ^ XOR_MASK;
      end
      if (state_r == ST_IDLE && in_fire && go_draw) begin
        y_r <= {diff[W-1-ROT_AMT:0], diff[W-1:W-ROT_AMT]};
      end
      if (state_r == ST_SEED_END) begin
        y_r <= prod + 64'd1;
      end
      if (state_r == ST_DRAW_END) begin
        x_r <= prod;
      end
      if (state_r == ST_OUT && take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      lo_r  <= in_data.range_low;
      red_r <= in_data.bounded && (span != '0);
      if (!go_draw) begin
        res_r.range_error <= in_data.range_low > in_data.range_high;
        res_r.value       <= (in_data.range_low > in_data.range_high) ?
                             '0 : in_data.range_low;
      end else begin
        res_r.range_error <= 1'b0;
        res_r.value       <= x_r;
      end
    end
    if (state_r == ST_DRAW_END && red_r) begin
      res_r.value <= lo_r + rem;
    end
    if (state_r == ST_OUT && take) begin
      out_r <= res_r;
    end
  end

  rdj_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  rdj_div u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (x_r),
    .divisor  (span),
    .rem      (rem)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
